>>> rtl/stsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_pkg
// types, token codes and constants shared by the token scanner modules
// ----------------------------------------------------------------------------
package stsc_pkg;

  // identifier bytes kept in name_packed
  localparam int NameChars = 8;
  // width of line and column counters
  localparam int PosBits = 16;
  // entries in the queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [63:0] NameMask = (NameChars >= 8) ? {64{1'b1}} :
                                     ((64'd1 << (8 * NameChars)) - 64'd1);
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [30:0] IntMax = {31{1'b1}};
  localparam logic [7:0] LenMax = 8'hFF;
  localparam logic [7:0] NewLine = 8'h0A;

  // keyword text, first character in the low byte
  localparam logic [63:0] KwIntText  = 64'h0000_0000_0074_6E69;
  localparam logic [63:0] KwVoidText = 64'h0000_0000_6469_6F76;
  localparam logic [63:0] KwFnText   = 64'h0000_0000_0000_6E66;
  localparam logic [63:0] KwLetText  = 64'h0000_0000_0074_656C;
  localparam logic [7:0] KwIntLen  = 8'd3;
  localparam logic [7:0] KwVoidLen = 8'd4;
  localparam logic [7:0] KwFnLen   = 8'd2;
  localparam logic [7:0] KwLetLen  = 8'd3;

  typedef enum logic [4:0] {
    KindEnd    = 5'd0,
    KindIdent  = 5'd1,
    KindInt    = 5'd2,
    KindKwInt  = 5'd3,
    KindKwVoid = 5'd4,
    KindKwFn   = 5'd5,
    KindKwLet  = 5'd6,
    KindPlus   = 5'd7,
    KindMinus  = 5'd8,
    KindStar   = 5'd9,
    KindSlash  = 5'd10,
    KindAssign = 5'd11,
    KindLParen = 5'd12,
    KindRParen = 5'd13,
    KindLBrack = 5'd14,
    KindRBrack = 5'd15,
    KindLBrace = 5'd16,
    KindRBrace = 5'd17,
    KindSemi   = 5'd18,
    KindComma  = 5'd19,
    KindColon  = 5'd20,
    KindError  = 5'd21
  } token_kind_e;

  typedef enum logic [1:0] {
    ScanIdle   = 2'd0,
    ScanIdent  = 2'd1,
    ScanNumber = 2'd2
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } tok_in_t;

  typedef struct packed {
    logic [4:0]         token_kind;
    logic [30:0]        int_value;
    logic               value_overflow;
    logic [63:0]        name_packed;
    logic [7:0]         name_length;
    logic               name_truncated;
    logic [PosBits-1:0] start_line;
    logic [PosBits-1:0] start_column;
    logic               last_of_run;
  } tok_out_t;

  // work for one accepted item: an optional flushed token, then an optional
  // single-character token (punctuator, error or end)
  typedef struct packed {
    tok_out_t           first;
    logic               has_first;
    token_kind_e        sec_kind;
    logic [PosBits-1:0] sec_line;
    logic [PosBits-1:0] sec_col;
    logic               has_second;
  } step_t;

  function automatic token_kind_e punct_kind(input logic [7:0] c);
    token_kind_e k;
    unique case (c)
      8'h2B:   k = KindPlus;    // +
      8'h2D:   k = KindMinus;   // -
      8'h2A:   k = KindStar;    // *
      8'h2F:   k = KindSlash;   // /
      8'h3D:   k = KindAssign;  // =
      8'h28:   k = KindLParen;  // (
      8'h29:   k = KindRParen;  // )
      8'h5B:   k = KindLBrack;  // [
      8'h5D:   k = KindRBrack;  // ]
      8'h7B:   k = KindLBrace;  // {
      8'h7D:   k = KindRBrace;  // }
      8'h3B:   k = KindSemi;    // ;
      8'h2C:   k = KindComma;   // ,
      8'h3A:   k = KindColon;   // :
      default: k = KindError;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/stsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_front
// classifies each byte, tracks position and the pending token, queues work
// ----------------------------------------------------------------------------
module stsc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  stsc_pkg::tok_in_t in_data_i,
  input  logic             q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output stsc_pkg::step_t  step_o
);
  import stsc_pkg::*;

  scan_mode_e         mode_q, mode_d;
  logic [63:0]        name_q, name_d;
  logic [7:0]         len_q, len_d;
  logic [30:0]        accum_q, accum_d;
  logic               sat_q, sat_d;
  logic [PosBits-1:0] line_q, line_d, col_q, col_d;
  logic [PosBits-1:0] tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic               halted_q, halted_d;

  logic               acc;
  logic [7:0]         c;
  logic               is_alpha, is_digit, is_space;
  logic               cont;
  logic [63:0]        base_name;
  logic [7:0]         base_len, len_inc;
  logic [30:0]        base_accum;
  logic               base_sat;
  logic [34:0]        acc_x10;
  logic               acc_over;
  logic [63:0]        name_app;
  logic [PosBits-1:0] adv_line, adv_col;
  tok_out_t           flush_tok;

  assign in_ready_o = !q_full_i;
  assign acc = in_valid_i && in_ready_o;
  assign c = in_data_i.char_byte;
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);

  // continue the pending token, else start from a cleared one
  assign cont = (mode_q == ScanIdent && (is_alpha || is_digit)) ||
                (mode_q == ScanNumber && is_digit);
  assign base_name  = cont ? name_q : 64'd0;
  assign base_len   = cont ? len_q : 8'd0;
  assign base_accum = cont ? accum_q : 31'd0;
  assign base_sat   = cont ? sat_q : 1'b0;
  assign len_inc    = (base_len == LenMax) ? LenMax : base_len + 8'd1;

  assign name_app = (base_len < 8'd8) ?
                    (base_name | (64'(c) << {base_len[2:0], 3'b000})) : base_name;
  assign acc_x10  = (35'(base_accum) << 3) + (35'(base_accum) << 1) + 35'(c - 8'h30);
  assign acc_over = acc_x10 > 35'(IntMax);

  assign adv_line = (c == NewLine && line_q != PosMax) ? line_q + 1'b1 : line_q;
  assign adv_col  = (c == NewLine) ? '0 : ((col_q != PosMax) ? col_q + 1'b1 : col_q);

  // token that a pending identifier or number turns into
  always_comb begin
    flush_tok = '0;
    flush_tok.start_line = tok_line_q;
    flush_tok.start_column = tok_col_q;
    if (mode_q == ScanNumber) begin
      flush_tok.token_kind = KindInt;
      flush_tok.int_value = accum_q;
      flush_tok.value_overflow = sat_q;
      flush_tok.name_length = len_q;
    end else if (len_q == KwIntLen && name_q == KwIntText) begin
      flush_tok.token_kind = KindKwInt;
    end else if (len_q == KwVoidLen && name_q == KwVoidText) begin
      flush_tok.token_kind = KindKwVoid;
    end else if (len_q == KwFnLen && name_q == KwFnText) begin
      flush_tok.token_kind = KindKwFn;
    end else if (len_q == KwLetLen && name_q == KwLetText) begin
      flush_tok.token_kind = KindKwLet;
    end else begin
      flush_tok.token_kind = KindIdent;
      flush_tok.name_packed = name_q & NameMask;
      flush_tok.name_length = len_q;
      flush_tok.name_truncated = len_q > 8'(NameChars);
    end
  end

  always_comb begin
    mode_d = mode_q;
    name_d = name_q;
    len_d = len_q;
    accum_d = accum_q;
    sat_d = sat_q;
    line_d = line_q;
    col_d = col_q;
    tok_line_d = tok_line_q;
    tok_col_d = tok_col_q;
    halted_d = halted_q;
    step_o = '0;
    step_o.first = flush_tok;
    step_o.sec_kind = KindEnd;
    step_o.sec_line = line_q;
    step_o.sec_col = col_q;
    if (acc && !halted_q) begin
      priority if (in_data_i.end_of_text) begin
        step_o.has_first = (mode_q != ScanIdle);
        step_o.has_second = 1'b1;
        mode_d = ScanIdle;
        name_d = '0;
        len_d = '0;
        accum_d = '0;
        sat_d = 1'b0;
        line_d = '0;
        col_d = '0;
        tok_line_d = '0;
        tok_col_d = '0;
      end else if (cont && mode_q == ScanIdent) begin
        name_d = name_app;
        len_d = len_inc;
        line_d = adv_line;
        col_d = adv_col;
      end else if (cont) begin
        accum_d = acc_over ? IntMax : acc_x10[30:0];
        sat_d = base_sat | acc_over;
        len_d = len_inc;
        line_d = adv_line;
        col_d = adv_col;
      end else begin
        step_o.has_first = (mode_q != ScanIdle);
        mode_d = ScanIdle;
        name_d = '0;
        len_d = '0;
        accum_d = '0;
        sat_d = 1'b0;
        priority if (is_space) begin
          // separator only
        end else if (is_alpha) begin
          mode_d = ScanIdent;
          tok_line_d = line_q;
          tok_col_d = col_q;
          name_d = name_app;
          len_d = len_inc;
        end else if (is_digit) begin
          mode_d = ScanNumber;
          tok_line_d = line_q;
          tok_col_d = col_q;
          accum_d = acc_x10[30:0];
          sat_d = 1'b0;
          len_d = len_inc;
        end else begin
          step_o.has_second = 1'b1;
          step_o.sec_kind = punct_kind(c);
          halted_d = (punct_kind(c) == KindError);
        end
        line_d = adv_line;
        col_d = adv_col;
      end
    end
    push_o = step_o.has_first || step_o.has_second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ScanIdle;
      name_q <= '0;
      len_q <= '0;
      accum_q <= '0;
      sat_q <= 1'b0;
      line_q <= '0;
      col_q <= '0;
      tok_line_q <= '0;
      tok_col_q <= '0;
      halted_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      name_q <= name_d;
      len_q <= len_d;
      accum_q <= accum_d;
      sat_q <= sat_d;
      line_q <= line_d;
      col_q <= col_d;
      tok_line_q <= tok_line_d;
      tok_col_q <= tok_col_d;
      halted_q <= halted_d;
    end
  end

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !push_o) else $error("queued work after error token");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && step_o.has_second && step_o.sec_kind == KindError) |=> halted_q)
    else $error("error token did not halt scanner");
`endif

endmodule

>>> rtl/stsc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_queue
// short fifo of scan steps between front and back
// ----------------------------------------------------------------------------
module stsc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stsc_pkg::step_t wr_data_i,
  input  logic            pop_i,
  output stsc_pkg::step_t rd_data_o,
  output logic            full_o,
  output logic            empty_o
);
  import stsc_pkg::*;

  step_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QueueCntW'(do_push) - QueueCntW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
`endif

endmodule

>>> rtl/stsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stsc_back
// expands each queued step into one or two tokens behind an output register
// ----------------------------------------------------------------------------
module stsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stsc_pkg::step_t  head_i,
  input  logic             q_empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stsc_pkg::tok_out_t out_data_o
);
  import stsc_pkg::*;

  logic     out_valid_q, out_valid_d;
  tok_out_t out_q;
  tok_out_t tok;
  logic     phase_q, phase_d;
  logic     load, take, emit_second;

  assign load = !out_valid_q || out_ready_i;
  assign take = load && !q_empty_i;
  // second half once the flushed token is out, or when there is none
  assign emit_second = phase_q || !head_i.has_first;

  always_comb begin
    if (emit_second) begin
      tok = '0;
      tok.token_kind = head_i.sec_kind;
      tok.start_line = head_i.sec_line;
      tok.start_column = head_i.sec_col;
      tok.last_of_run = 1'b1;
    end else begin
      tok = head_i.first;
      tok.last_of_run = !head_i.has_second;
    end
    pop_o = take && (emit_second || !head_i.has_second);
    phase_d = take ? (!emit_second && head_i.has_second) : phase_q;
    out_valid_d = load ? !q_empty_i : out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q <= phase_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_phase_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> !q_empty_i) else $error("second half pending with empty queue");
`endif

endmodule

>>> rtl/source_token_scanner.sv
`timescale 1ns / 1ps
// a token reaches the output register through the step queue after its item is accepted
// throughput: one item per cycle if the queue is not full; one token per cycle if out_ready_i
// an item that ends a pending token and carries its own gives two tokens, one after the other
// the 4-entry step queue absorbs those bursts; input stalls only when it is full
// reset clears position, pending token, halt flag, queue pointers and output valid
// ----------------------------------------------------------------------------
// source_token_scanner
// streaming lexer: bytes in, tokens with start line and column out
// ----------------------------------------------------------------------------
module source_token_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stsc_pkg::tok_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stsc_pkg::tok_out_t out_data_o
);
  import stsc_pkg::*;

  // front to queue
  logic  push;
  step_t push_step;
  // queue to back
  step_t head;
  logic  q_full, q_empty, pop;

  // front: classifies each byte, keeps line/column and the pending token,
  // and writes one step per item that yields any token
  stsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .step_o     (push_step)
  );

  // decouples front and back so either side can stall alone
  stsc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (push_step),
    .pop_i     (pop),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // back: splits a step into its tokens, marks the last one of the item
  stsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_push_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_valid_i && in_ready_o)) else $error("step queued without accepted item");
`endif

endmodule

>>> tb/source_token_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_token_scanner_tb
// feeds the token scanner source text under random sender bursts and receiver
// stalls, predicts every token with its own scanner copy and compares each
// token field by field in arrival order
// ----------------------------------------------------------------------------
module source_token_scanner_tb;
  import stsc_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int RandomItems = 420;

  // --------------------------------------------------------------------------
  // token predictor and store of expected tokens
  // --------------------------------------------------------------------------
  class token_stream_checker;
    // scanner state kept alongside the block
    scan_mode_e         mode;
    logic [63:0]        name_bytes;
    logic [7:0]         run_len;
    logic [30:0]        accum;
    logic               accum_sat;
    logic [PosBits-1:0] line_now;
    logic [PosBits-1:0] col_now;
    logic [PosBits-1:0] tok_line;
    logic [PosBits-1:0] tok_col;
    bit                 stopped;

    logic [7:0] punct_set [14] = '{"+", "-", "*", "/", "=", "(", ")", "[", "]",
                                   "{", "}", ";", ",", ":"};

    tok_out_t step_tokens[$];
    tok_out_t expected_tokens[$];
    int n_items;
    int n_checked;
    int n_ends;
    int n_errors;

    function new();
      clear_pending();
      line_now = '0;
      col_now = '0;
      tok_line = '0;
      tok_col = '0;
      stopped = 0;
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // punctuators map in table order onto the kinds from KindPlus on
    function logic [4:0] punct_code(logic [7:0] c);
      for (int i = 0; i < 14; i++) begin
        if (c == punct_set[i]) return 5'(KindPlus) + 5'(i);
      end
      return KindError;
    endfunction

    function void clear_pending();
      mode = ScanIdle;
      name_bytes = '0;
      run_len = '0;
      accum = '0;
      accum_sat = 1'b0;
    endfunction

    function tok_out_t blank_token(logic [4:0] kind, logic [PosBits-1:0] ln,
                                   logic [PosBits-1:0] col);
      tok_out_t t;
      t = '0;
      t.token_kind = kind;
      t.start_line = ln;
      t.start_column = col;
      return t;
    endfunction

    // emit the identifier, keyword or number under way, if any
    function void flush_pending();
      tok_out_t t;
      t = blank_token(KindIdent, tok_line, tok_col);
      if (mode == ScanIdent) begin
        if (run_len == KwIntLen && name_bytes == KwIntText) t.token_kind = KindKwInt;
        else if (run_len == KwVoidLen && name_bytes == KwVoidText) t.token_kind = KindKwVoid;
        else if (run_len == KwFnLen && name_bytes == KwFnText) t.token_kind = KindKwFn;
        else if (run_len == KwLetLen && name_bytes == KwLetText) t.token_kind = KindKwLet;
        else begin
          t.name_packed = name_bytes & NameMask;
          t.name_length = run_len;
          t.name_truncated = (run_len > NameChars);
        end
        step_tokens = {step_tokens, t};
      end else if (mode == ScanNumber) begin
        t.token_kind = KindInt;
        t.int_value = accum;
        t.value_overflow = accum_sat;
        t.name_length = run_len;
        step_tokens = {step_tokens, t};
      end
      clear_pending();
    endfunction

    function void add_letter(logic [7:0] c);
      if (run_len < 8) name_bytes[8*run_len +: 8] = c;
      if (run_len != LenMax) run_len++;
    endfunction

    function void add_digit(logic [7:0] c);
      longint unsigned v;
      v = 64'(accum) * 10 + 64'(c - 8'h30);
      if (v > 64'(IntMax)) begin
        v = 64'(IntMax);
        accum_sat = 1'b1;
      end
      accum = v[30:0];
      if (run_len != LenMax) run_len++;
    endfunction

    function void advance(logic [7:0] c);
      if (c == NewLine) begin
        if (line_now != PosMax) line_now++;
        col_now = '0;
      end else if (col_now != PosMax) begin
        col_now++;
      end
    endfunction

    function void note_item(tok_in_t it);
      logic [7:0] c;
      logic [4:0] kind;
      step_tokens.delete();
      n_items++;
      c = it.char_byte;
      if (stopped) return;
      if (it.end_of_text) begin
        flush_pending();
        step_tokens = {step_tokens, blank_token(KindEnd, line_now, col_now)};
        line_now = '0;
        col_now = '0;
        tok_line = '0;
        tok_col = '0;
        n_ends++;
      end else if (mode == ScanIdent && (is_letter(c) || is_digit(c))) begin
        add_letter(c);
        advance(c);
      end else if (mode == ScanNumber && is_digit(c)) begin
        add_digit(c);
        advance(c);
      end else begin
        flush_pending();
        if (is_letter(c)) begin
          mode = ScanIdent;
          tok_line = line_now;
          tok_col = col_now;
          add_letter(c);
        end else if (is_digit(c)) begin
          mode = ScanNumber;
          tok_line = line_now;
          tok_col = col_now;
          add_digit(c);
        end else if (!is_blank(c)) begin
          kind = punct_code(c);
          step_tokens = {step_tokens, blank_token(kind, line_now, col_now)};
          if (kind == KindError) stopped = 1;
        end
        advance(c);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
      foreach (step_tokens[i]) expected_tokens = {expected_tokens, step_tokens[i]};
    endfunction

    function void check_field(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t ns: token %0d %s expected %0h got %0h", $time, n_checked, fname,
                 want, got);
        n_errors++;
      end
    endfunction

    function void check_token(tok_out_t got);
      tok_out_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t ns: token kind %0d expected none got one at line %0d col %0d",
                 $time, got.token_kind, got.start_line, got.start_column);
        n_errors++;
        return;
      end
      want = expected_tokens[0];
      expected_tokens.delete(0);
      check_field("token_kind", want.token_kind, got.token_kind);
      check_field("int_value", want.int_value, got.int_value);
      check_field("value_overflow", want.value_overflow, got.value_overflow);
      check_field("name_packed", want.name_packed, got.name_packed);
      check_field("name_length", want.name_length, got.name_length);
      check_field("name_truncated", want.name_truncated, got.name_truncated);
      check_field("start_line", want.start_line, got.start_line);
      check_field("start_column", want.start_column, got.start_column);
      check_field("last_of_run", want.last_of_run, got.last_of_run);
      n_checked++;
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid_q = 1'b0;
  tok_in_t  in_data_q = '0;
  logic     out_ready_q = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  tok_out_t out_data_o;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  source_token_scanner DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_q),
    .out_data_o (out_data_o)
  );

  token_stream_checker sb;

  // both handshakes are seen at the same edge; the item is noted before any
  // token is checked so ordering within the step never matters
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid_q && in_ready_o) sb.note_item(in_data_q);
      if (out_valid_o && out_ready_q) sb.check_token(out_data_o);
    end
  end

  // watchdog: a hang or a lost token ends here
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles with %0d tokens outstanding", cycles,
               sb.expected_tokens.size());
      $display("** source_token_scanner: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: switches between free flow, random stalls, a fixed rhythm and
  // long stalls, each for a random stretch of cycles
  // --------------------------------------------------------------------------
  int rx_pattern = 0;
  int rx_left = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = $urandom_range(0, 3);
      rx_left = $urandom_range(40, 400);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      0: out_ready_q <= 1'b1;
      1: out_ready_q <= ($urandom_range(0, 3) != 0);
      2: out_ready_q <= (rx_left % 3 != 0);
      default: begin
        // long stall, then a single ready cycle
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready_q <= 1'b0;
        end else begin
          rx_hold = $urandom_range(0, 16);
          out_ready_q <= 1'b1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sender: bursts of random length separated by random gaps; tx_steady turns
  // the gaps off for the long name and number runs
  // --------------------------------------------------------------------------
  int tx_burst_left = 0;
  bit tx_steady = 0;
  int n_sent = 0;

  task automatic push_item(input tok_in_t it);
    int gap;
    if (tx_burst_left == 0 && !tx_steady) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      tx_burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_q <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid_q <= 1'b1;
    in_data_q <= it;
    // hold the item until the block takes it
    do @(posedge clk); while (!in_ready_o);
    if (tx_burst_left > 0) tx_burst_left--;
    n_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    tok_in_t it;
    it.char_byte = c;
    it.end_of_text = 1'b0;
    push_item(it);
  endtask

  // end of text with a random byte that the block must ignore
  task automatic send_end();
    tok_in_t it;
    it.char_byte = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    push_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] any_letter();
    return ($urandom_range(0, 1) != 0) ? 8'("a" + $urandom_range(0, 25))
                                        : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_blank();
    logic [7:0] blanks [7] = '{8'd32, 8'd32, 8'd9, NewLine, 8'd11, 8'd12, 8'd13};
    return blanks[$urandom_range(0, 6)];
  endfunction

  function automatic bit is_legal(logic [7:0] c);
    return sb.is_letter(c) || sb.is_digit(c) || sb.is_blank(c) ||
           sb.punct_code(c) != KindError;
  endfunction

  // keywords and near misses around them
  string kw_words [10] = '{"int", "void", "fn", "let", "in", "voids", "fnord", "Let",
                           "f", "lett"};
  string num_words [5] = '{"2147483647", "2147483648", "0", "000123", "99999999999"};

  // one well-formed token, or now and then some legal noise or an end mark
  task automatic send_random_token();
    int pick;
    int len;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_text(kw_words[$urandom_range(0, 9)]);
    end else if (pick < 35) begin
      len = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 11);
      send_char(any_letter());
      for (int i = 1; i < len; i++) send_char(($urandom_range(0, 3) == 0) ? any_digit()
                                                                        : any_letter());
    end else if (pick < 52) begin
      if ($urandom_range(0, 4) == 0) begin
        send_text(num_words[$urandom_range(0, 4)]);
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 25) : $urandom_range(1, 10);
        repeat (len) send_char(any_digit());
      end
    end else if (pick < 72) begin
      send_char(sb.punct_set[$urandom_range(0, 13)]);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) send_char(any_blank());
    end else if (pick < 96) begin
      // legal noise
      do c = 8'($urandom_range(0, 127)); while (!is_legal(c));
      send_char(c);
    end else begin
      send_end();
    end
    // tokens are usually separated, but often run straight into each other
    if ($urandom_range(0, 9) < 6) send_char(any_blank());
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] bad;
    int random_goal;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every keyword and punctuator, a newline, a pending number flushed by
    // end of text, then end of text with nothing pending
    send_text("let fn=int(void)\n x1[9]+-*/{};,:\t7");
    send_end();
    send_end();

    // random text
    random_goal = n_sent + RandomItems;
    while (n_sent < random_goal) send_random_token();
    send_end();

    // over-long name and number, sent without gaps
    tx_steady = 1;
    send_text("abc=9;");
    send_char(NewLine);
    repeat (300) send_char(any_letter());
    send_char(8'd32);
    repeat (30) send_char(any_digit());
    send_text("z;");
    send_end();
    tx_steady = 0;

    // an illegal byte after a pending name halts the scanner for good; what
    // follows, end of text included, must give nothing
    send_text("qr");
    bad = 8'($urandom_range(128, 255));
    send_char(bad);
    repeat (5) send_char(8'($urandom_range(0, 255)));
    send_end();
    in_valid_q <= 1'b0;

    while (sb.expected_tokens.size() > 0) @(posedge clk);
    // stray tokens would still show up here
    repeat (20) @(posedge clk);

    $display("covered %0d items and %0d tokens over %0d texts in %0d cycles",
             sb.n_items, sb.n_checked, sb.n_ends, cycles);
    $display("with keywords, all punctuators, saturated values and lengths, long names, halt");
    if (sb.n_errors == 0) begin
      $display("** source_token_scanner: PASSED **");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("** source_token_scanner: FAILED **");
    end
    $finish;
  end

endmodule
